@@ hw/rtl/gcrb_pkg.sv @@
// ----------------------------------------------------------------------------
// gcrb_pkg
// Shared types and constants for the greedy capacitated route builder.
// ----------------------------------------------------------------------------
package gcrb_pkg;

    // Fixed field widths
    localparam int CMD_W      = 2;
    localparam int VFIELD_W   = 4;
    localparam int AMT_W      = 10;
    localparam int DIST_W     = 16;
    localparam int CNT_W      = 5;
    localparam int LOAD_W     = 11;
    localparam int FIELD_SPAN = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 1;

    // Command codes carried in the input item
    localparam logic [CMD_W-1:0] CMD_EDGE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEMAND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WR1,
        ST_WR2,
        ST_START,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_RET_RD,
        ST_RET,
        ST_FIN_RD,
        ST_FIN
    } state_t;

    // What goes into the output register this cycle
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_START,
        EMIT_STOP,
        EMIT_DEPOT,
        EMIT_FINAL,
        EMIT_ABORT
    } emit_t;

    // Controller -> datapath
    typedef struct packed {
        logic  latch_in;
        logic  wr_fwd;
        logic  wr_rev;
        logic  run_clear;
        logic  scan_init;
        logic  scan_issue;
        logic  take_best;
        logic  ret_read;
        logic  ret_apply;
        logic  fin_apply;
        emit_t emit;
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [CMD_W-1:0] in_cmd;
        logic             in_addr_ok;
        logic             out_free;
        logic             scan_done;
        logic             found;
        logic             cur_zero;
        logic             rem_last;
    } dp_stat_t;

endpackage

@@ hw/rtl/gcrb_dp.sv @@
// ----------------------------------------------------------------------------
// gcrb_dp
// Datapath: matrix store, configuration registers, route state, candidate
// scan comparator and the output register.
// ----------------------------------------------------------------------------
module gcrb_dp import gcrb_pkg::*; #(
    parameter int MAX_VERTICES    = 16,
    parameter int NO_ROUTE_WEIGHT = 999
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [AMT_W-1:0]     cfg_data,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int VCNT  = 1 << VW;
    localparam int DEPTH = VCNT * VCNT;
    localparam int AW    = 2 * VW;
    localparam int NLIM  = (MAX_VERTICES < FIELD_SPAN) ? MAX_VERTICES : FIELD_SPAN;

    // Input item fields
    logic [CMD_W-1:0]    in_cmd;
    logic [VFIELD_W-1:0] in_a;
    logic [VFIELD_W-1:0] in_b;
    logic [AMT_W-1:0]    in_amt;

    assign in_cmd = s_tdata[1:0];
    assign in_a   = s_tdata[5:2];
    assign in_b   = s_tdata[9:6];
    assign in_amt = s_tdata[19:10];

    logic a_ok, b_ok;
    assign a_ok = int'(in_a) < MAX_VERTICES;
    assign b_ok = int'(in_b) < MAX_VERTICES;

    // Latched load item; a demand load writes its diagonal entry twice
    logic [VW-1:0]    wa_reg, wb_reg;
    logic [AMT_W-1:0] wamt_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            wa_reg   <= VW'(in_a);
            wb_reg   <= (in_cmd == CMD_DEMAND) ? VW'(in_a) : VW'(in_b);
            wamt_reg <= in_amt;
        end
    end

    // Configuration registers
    logic [CNT_W-1:0] vcount_reg;
    logic [AMT_W-1:0] cap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= CNT_W'(16);
            cap_reg    <= AMT_W'(1023);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_VERTEX_COUNT: vcount_reg <= cfg_data[CNT_W-1:0];
                CFG_CAPACITY:     cap_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Vertex count in use, clamped
    logic [CNT_W-1:0] n_eff;
    always_comb begin
        if (vcount_reg < CNT_W'(2))
            n_eff = CNT_W'(2);
        else if (int'(vcount_reg) > NLIM)
            n_eff = CNT_W'(NLIM);
        else
            n_eff = vcount_reg;
    end

    // Route state
    logic [VCNT-1:0]   visited_reg;
    logic [LOAD_W-1:0] load_reg;
    logic [VW-1:0]     cur_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [VW-1:0]     j_reg, jd_reg;
    logic              rdv_reg;
    logic [VW-1:0]     best_reg;
    logic [AMT_W-1:0]  bestw_reg, bestd_reg;
    logic              found_reg;

    // Matrix store: one write port, two registered read ports
    logic [AMT_W-1:0] mem [DEPTH];
    logic [AMT_W-1:0] qa_reg, qb_reg;
    logic [AW-1:0]    waddr, raddr_a, raddr_b;
    logic             mem_we, rd_en;

    assign mem_we  = cmd.wr_fwd | cmd.wr_rev;
    assign waddr   = cmd.wr_fwd ? {wa_reg, wb_reg} : {wb_reg, wa_reg};
    assign rd_en   = cmd.scan_issue | cmd.ret_read;
    assign raddr_a = cmd.ret_read ? {cur_reg, VW'(0)} : {cur_reg, j_reg};
    assign raddr_b = {j_reg, j_reg};

    always_ff @(posedge aclk) begin
        if (mem_we)
            mem[waddr] <= wamt_reg;
        if (rd_en) begin
            qa_reg <= mem[raddr_a];
            qb_reg <= mem[raddr_b];
        end
    end

    // Candidate test on the data read in the previous cycle
    logic [LOAD_W:0] load_sum;
    logic            cand;
    assign load_sum = {1'b0, load_reg} + (LOAD_W + 1)'(qb_reg);
    assign cand = rdv_reg && !visited_reg[jd_reg] && (qa_reg < bestw_reg)
               && (load_sum <= (LOAD_W + 1)'(cap_reg));

    // Saturating distance adds
    logic [DIST_W:0]   sum_best, sum_ret;
    logic [DIST_W-1:0] dist_best, dist_ret, dist_fin;
    assign sum_best  = {1'b0, dist_reg} + (DIST_W + 1)'(bestw_reg);
    assign sum_ret   = {1'b0, dist_reg} + (DIST_W + 1)'(qa_reg);
    assign dist_best = sum_best[DIST_W] ? '1 : sum_best[DIST_W-1:0];
    assign dist_ret  = sum_ret[DIST_W] ? '1 : sum_ret[DIST_W-1:0];
    assign dist_fin  = (cur_reg != '0) ? dist_ret : dist_reg;

    // Route state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visited_reg <= '0;
            load_reg    <= '0;
            cur_reg     <= '0;
            dist_reg    <= '0;
            rem_reg     <= '0;
            j_reg       <= VW'(1);
            rdv_reg     <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            rdv_reg <= cmd.scan_issue;
            if (cmd.run_clear) begin
                visited_reg <= '0;
                load_reg    <= '0;
                cur_reg     <= '0;
                dist_reg    <= '0;
                rem_reg     <= n_eff - CNT_W'(1);
            end
            if (cmd.scan_init) begin
                j_reg     <= VW'(1);
                bestw_reg <= AMT_W'(NO_ROUTE_WEIGHT);
                found_reg <= 1'b0;
            end
            if (cmd.scan_issue) begin
                j_reg  <= j_reg + VW'(1);
                jd_reg <= j_reg;
            end
            if (cand) begin
                best_reg  <= jd_reg;
                bestw_reg <= qa_reg;
                bestd_reg <= qb_reg;
                found_reg <= 1'b1;
            end
            if (cmd.take_best) begin
                dist_reg              <= dist_best;
                load_reg              <= load_reg + LOAD_W'(bestd_reg);
                visited_reg[best_reg] <= 1'b1;
                cur_reg               <= best_reg;
                rem_reg               <= rem_reg - CNT_W'(1);
            end
            if (cmd.ret_apply) begin
                dist_reg <= dist_ret;
                cur_reg  <= '0;
                load_reg <= '0;
            end
            if (cmd.fin_apply) begin
                dist_reg <= dist_fin;
                cur_reg  <= '0;
                load_reg <= '0;
            end
        end
    end

    // Output register
    logic              ovalid_reg;
    logic [3:0]        ostop_reg;
    logic [DIST_W-1:0] odist_reg;
    logic              olast_reg, oerr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            ovalid_reg <= 1'b0;
        else if (cmd.emit != EMIT_NONE)
            ovalid_reg <= 1'b1;
        else if (m_tready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        case (cmd.emit)
            EMIT_START, EMIT_DEPOT: begin
                ostop_reg <= '0;
                odist_reg <= '0;
                olast_reg <= 1'b0;
                oerr_reg  <= 1'b0;
            end
            EMIT_STOP: begin
                ostop_reg <= VFIELD_W'(best_reg);
                odist_reg <= '0;
                olast_reg <= 1'b0;
                oerr_reg  <= 1'b0;
            end
            EMIT_FINAL: begin
                ostop_reg <= '0;
                odist_reg <= dist_fin;
                olast_reg <= 1'b1;
                oerr_reg  <= 1'b0;
            end
            EMIT_ABORT: begin
                ostop_reg <= '0;
                odist_reg <= dist_reg;
                olast_reg <= 1'b1;
                oerr_reg  <= 1'b1;
            end
            default: ;
        endcase
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {4'b0, odist_reg, ostop_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = oerr_reg;

    // Status to controller
    assign stat.in_cmd     = in_cmd;
    assign stat.in_addr_ok = (in_cmd == CMD_EDGE) ? (a_ok && b_ok) : a_ok;
    assign stat.out_free   = !ovalid_reg || m_tready;
    assign stat.scan_done  = (CNT_W'(j_reg) == (n_eff - CNT_W'(1)));
    assign stat.found      = found_reg;
    assign stat.cur_zero   = (cur_reg == '0);
    assign stat.rem_last   = (rem_reg == CNT_W'(1));

    // An aborted run is always the final item
    assert property (@(posedge aclk) disable iff (!aresetn)
        ovalid_reg && oerr_reg |-> olast_reg)
        else $error("abort flag on a non-final item");

    // Distance is reported only on the final item
    assert property (@(posedge aclk) disable iff (!aresetn)
        ovalid_reg && !olast_reg |-> odist_reg == '0)
        else $error("nonzero distance on an intermediate item");

    // The depot is never marked as a visited customer
    assert property (@(posedge aclk) disable iff (!aresetn)
        !visited_reg[0])
        else $error("depot marked visited");

endmodule

@@ hw/rtl/gcrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// gcrb_ctrl
// Controller: sequences matrix loads and the greedy route scan.
// ----------------------------------------------------------------------------
module gcrb_ctrl import gcrb_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (stat.in_cmd)
                        CMD_EDGE, CMD_DEMAND: state_next = stat.in_addr_ok ? ST_WR1 : ST_IDLE;
                        CMD_RUN:              state_next = ST_START;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WR1:       state_next = ST_WR2;
            ST_WR2:       state_next = ST_IDLE;
            ST_START:     if (stat.out_free) state_next = ST_SCAN_INIT;
            ST_SCAN_INIT: state_next = ST_SCAN;
            ST_SCAN:      if (stat.scan_done) state_next = ST_DRAIN;
            ST_DRAIN:     state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (stat.found) begin
                    if (stat.out_free)
                        state_next = stat.rem_last ? ST_FIN_RD : ST_SCAN_INIT;
                end else if (stat.cur_zero) begin
                    if (stat.out_free) state_next = ST_IDLE;
                end else begin
                    state_next = ST_RET_RD;
                end
            end
            ST_RET_RD:    state_next = ST_RET;
            ST_RET:       if (stat.out_free) state_next = ST_SCAN_INIT;
            ST_FIN_RD:    state_next = ST_FIN;
            ST_FIN:       if (stat.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        cmd.emit = EMIT_NONE;
        case (state_reg)
            ST_IDLE: begin
                s_tready     = 1'b1;
                cmd.latch_in = s_tvalid;
            end
            ST_WR1:       cmd.wr_fwd = 1'b1;
            ST_WR2:       cmd.wr_rev = 1'b1;
            ST_START: begin
                if (stat.out_free) begin
                    cmd.run_clear = 1'b1;
                    cmd.emit      = EMIT_START;
                end
            end
            ST_SCAN_INIT: cmd.scan_init = 1'b1;
            ST_SCAN:      cmd.scan_issue = 1'b1;
            ST_DRAIN:     ;
            ST_DECIDE: begin
                if (stat.out_free) begin
                    if (stat.found) begin
                        cmd.take_best = 1'b1;
                        cmd.emit      = EMIT_STOP;
                    end else if (stat.cur_zero) begin
                        cmd.emit = EMIT_ABORT;
                    end
                end
            end
            ST_RET_RD, ST_FIN_RD: cmd.ret_read = 1'b1;
            ST_RET: begin
                if (stat.out_free) begin
                    cmd.ret_apply = 1'b1;
                    cmd.emit      = EMIT_DEPOT;
                end
            end
            ST_FIN: begin
                if (stat.out_free) begin
                    cmd.fin_apply = 1'b1;
                    cmd.emit      = EMIT_FINAL;
                end
            end
            default: ;
        endcase
    end

    // Never load the output register over an item still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit != EMIT_NONE |-> stat.out_free)
        else $error("output item overwritten");

    // A stop is taken only after the scan found one
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_best |-> stat.found)
        else $error("stop taken without candidate");

    // The scan runs until the last vertex address is issued
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN && !stat.scan_done |=> state_reg == ST_SCAN)
        else $error("scan left early");

endmodule

@@ hw/rtl/greedy_capacitated_route_builder.sv @@
// ----------------------------------------------------------------------------
// greedy_capacitated_route_builder
// Nearest-neighbor route builder for a capacitated vehicle, depot at vertex 0.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one command item at a time. Edge and demand loads are
//   accepted, then write the matrix entry and its mirror entry in turn.
//   A run item builds one route and streams its stops on the m_ channel:
//   the depot start, each customer, each depot return, and a final item with
//   tlast set and the route length; tuser marks an aborted run.
//   Each route step scans the customer vertices through the two read ports
//   of the matrix store, one vertex per cycle; a depot return first reads
//   the return weight. A new item is taken once the run's final item is in
//   the output register.
//   cfg_ writes the vertex count and capacity; cfg_ready is always high.
//   Reset clears the controller and output valid and sets the configuration
//   to 16 vertices and capacity 1023; matrix entries are undefined until
//   written. A stalled receiver holds the current item and pauses the run.
// ----------------------------------------------------------------------------
module greedy_capacitated_route_builder import gcrb_pkg::*; #(
    parameter int MAX_VERTICES    = 16,
    parameter int NO_ROUTE_WEIGHT = 999
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // cmd[1:0], vertex_a[5:2], vertex_b[9:6], amount[19:10], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // stop_vertex[3:0], total_distance[19:4], zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    // unreachable[0]
    output logic                 m_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [AMT_W-1:0]     cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    gcrb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    gcrb_dp #(
        .MAX_VERTICES    (MAX_VERTICES),
        .NO_ROUTE_WEIGHT (NO_ROUTE_WEIGHT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

@@ tb/greedy_capacitated_route_builder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// greedy_capacitated_route_builder_tb
// Self-checking bench for the nearest-neighbor capacitated route builder.
// A short directed table covers small hand-checked routes, capacity and
// weight limits and ignored commands. The whole matrix is then filled and
// random phases mix loads and runs under changing vertex counts and
// capacities. Every route stop is checked against hand-typed stops or an
// in-bench route planner. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module greedy_capacitated_route_builder_tb import gcrb_pkg::*; ();

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 9;
    localparam int NV           = 16;
    localparam int NO_ROUTE     = 999;
    localparam int ITEM_GOAL    = 400;
    localparam int CALM_ITEMS   = 40;
    localparam int SETTLE       = 8;
    localparam int TAIL         = 40;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [VFIELD_W-1:0] vertex;
        logic [DIST_W-1:0]   total;
        logic                last;
        logic                unreach;
    } stop_t;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CMD_W-1:0]     cmd;
        logic [VFIELD_W-1:0]  a;
        logic [VFIELD_W-1:0]  b;
        logic [AMT_W-1:0]     amt;
        logic [CFG_IDX_W-1:0] idx;
        int                   typed_n;
    } row_t;

    // DUT ports
    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [AMT_W-1:0]     cfg_data = '0;

    // Route planner state
    logic [AMT_W-1:0]    wmat [0:NV-1][0:NV-1];
    logic [NV-1:0]       visited;
    logic [LOAD_W-1:0]   load_now;
    logic [VFIELD_W-1:0] at_vertex;
    logic [DIST_W-1:0]   dist_sum;
    logic [CNT_W-1:0]    vcount;
    logic [AMT_W-1:0]    capacity;

    stop_t new_stops[$];
    stop_t expected_stops[$];
    stop_t typed_stops[$];
    row_t  rows[$];

    int  mismatches   = 0;
    int  items_sent   = 0;
    int  cycles       = 0;
    int  stall_left   = 0;
    int  rx_stall_pct = 25;
    bit  calm         = 1'b0;
    bit  idle_on      = 1'b1;

    greedy_capacitated_route_builder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Route planner
    // ------------------------------------------------------------------
    function automatic logic [DIST_W-1:0] sat_add(logic [DIST_W-1:0] x, int y);
        int s;
        s = int'(x) + y;
        return (s > 65535) ? 16'hFFFF : s[DIST_W-1:0];
    endfunction

    function automatic void add_stop(logic [VFIELD_W-1:0] v, logic [DIST_W-1:0] d,
                                     logic l, logic u);
        stop_t s;
        s = {v, d, l, u};
        new_stops = {new_stops, s};
    endfunction

    function automatic void plan_route();
        int n;
        int remaining;
        int best;
        int best_w;
        int w;
        n = int'(vcount);
        if (n < 2) n = 2;
        if (n > NV) n = NV;
        visited   = '0;
        load_now  = '0;
        at_vertex = '0;
        dist_sum  = '0;
        add_stop(0, 0, 1'b0, 1'b0);
        remaining = n - 1;
        while (remaining > 0) begin
            best   = n;
            best_w = NO_ROUTE;
            // nearest unvisited customer that still fits, lowest index on a tie
            for (int j = 1; j < n; j++) begin
                w = int'(wmat[at_vertex][j]);
                if (!visited[j] && w < best_w &&
                    int'(load_now) + int'(wmat[j][j]) <= int'(capacity)) begin
                    best   = j;
                    best_w = w;
                end
            end
            if (best < n) begin
                dist_sum  = sat_add(dist_sum, best_w);
                load_now  = load_now + LOAD_W'(wmat[best][best]);
                visited[best] = 1'b1;
                at_vertex = 4'(best);
                remaining--;
                add_stop(4'(best), 0, 1'b0, 1'b0);
            end else if (at_vertex == 0) begin
                // stuck at the depot: some customer can never be served
                add_stop(0, dist_sum, 1'b1, 1'b1);
                return;
            end else begin
                // head back to the depot and unload
                dist_sum  = sat_add(dist_sum, int'(wmat[at_vertex][0]));
                at_vertex = '0;
                load_now  = '0;
                add_stop(0, 0, 1'b0, 1'b0);
            end
        end
        if (at_vertex != 0) dist_sum = sat_add(dist_sum, int'(wmat[at_vertex][0]));
        at_vertex = '0;
        load_now  = '0;
        add_stop(0, dist_sum, 1'b1, 1'b0);
    endfunction

    function automatic void apply_command(logic [CMD_W-1:0] cmd, logic [VFIELD_W-1:0] a,
                                          logic [VFIELD_W-1:0] b, logic [AMT_W-1:0] amt);
        new_stops.delete();
        case (cmd)
            CMD_EDGE: begin
                wmat[a][b] = amt;
                wmat[b][a] = amt;
            end
            CMD_DEMAND: wmat[a][a] = amt;
            CMD_RUN:    plan_route();
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Random values
    // ------------------------------------------------------------------
    function automatic logic [AMT_W-1:0] rand_weight();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 10'($urandom_range(0, 50));
        if (roll < 75) return 10'($urandom_range(995, 1023));
        return 10'($urandom_range(0, 1023));
    endfunction

    function automatic logic [AMT_W-1:0] rand_demand();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 10'($urandom_range(0, 40));
        if (roll < 85) return 10'($urandom_range(0, 300));
        return 10'($urandom_range(0, 1023));
    endfunction

    // ------------------------------------------------------------------
    // Table building
    // ------------------------------------------------------------------
    function automatic void row_item(logic [CMD_W-1:0] cmd, logic [VFIELD_W-1:0] a,
                                     logic [VFIELD_W-1:0] b, logic [AMT_W-1:0] amt,
                                     int typed_n);
        row_t r;
        r = '{kind: ROW_ITEM, cmd: cmd, a: a, b: b, amt: amt, idx: '0, typed_n: typed_n};
        rows = {rows, r};
    endfunction

    function automatic void row_cfg(logic [CFG_IDX_W-1:0] idx, logic [AMT_W-1:0] data);
        row_t r;
        r = '{kind: ROW_CFG, cmd: CMD_UNUSED, a: '0, b: '0, amt: data, idx: idx,
              typed_n: 0};
        rows = {rows, r};
    endfunction

    function automatic void typed(logic [VFIELD_W-1:0] v, logic [DIST_W-1:0] d,
                                  logic l, logic u);
        stop_t s;
        s = {v, d, l, u};
        typed_stops = {typed_stops, s};
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    task automatic rest(input int n);
        s_tvalid = 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (expected_stops.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VFIELD_W-1:0] a,
                             input logic [VFIELD_W-1:0] b, input logic [AMT_W-1:0] amt,
                             input int typed_n);
        stop_t s;
        s_tdata  = {4'b0, amt, b, a, cmd};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        apply_command(cmd, a, b, amt);
        if (typed_n > 0) begin
            repeat (typed_n) begin
                s = typed_stops.pop_front();
                expected_stops = {expected_stops, s};
            end
        end else begin
            expected_stops = {expected_stops, new_stops};
        end
        if (cmd != CMD_UNUSED) items_sent++;
        @(negedge aclk);
        if (!calm && idle_on && $urandom_range(0, 3) == 0) rest($urandom_range(1, 4));
    endtask

    // registers change only with the block idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [AMT_W-1:0] data);
        drain();
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_VERTEX_COUNT) vcount = data[CNT_W-1:0];
        else capacity = data;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver stalls: random bursts of low ready, with ready high between
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else if (!m_tready) begin
            m_tready = 1'b1;
        end else if (!calm && $urandom_range(1, 100) <= rx_stall_pct) begin
            m_tready   = 1'b0;
            stall_left = $urandom_range(0, 3);
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        stop_t got;
        stop_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[3:0], m_tdata[19:4], m_tlast, m_tuser};
            if (expected_stops.size() == 0) begin
                $display("%0t: unexpected stop: vertex %0d dist %0d last %0d unreachable %0d",
                         $time, got.vertex, got.total, got.last, got.unreach);
                mismatches++;
            end else begin
                want = expected_stops.pop_front();
                if (got != want) begin
                    $display("%0t: stop mismatch: expected vertex %0d dist %0d last %0d %s",
                             $time, want.vertex, want.total, want.last,
                             $sformatf("unreachable %0d, got vertex %0d dist %0d last %0d %s",
                                       want.unreach, got.vertex, got.total, got.last,
                                       $sformatf("unreachable %0d", got.unreach)));
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int roll;
        int batch;
        logic [VFIELD_W-1:0] va;
        logic [VFIELD_W-1:0] vb;
        logic [AMT_W-1:0] cap_pick;

        // planner reset state
        foreach (wmat[r, c]) wmat[r][c] = '0;
        visited   = '0;
        load_now  = '0;
        at_vertex = '0;
        dist_sum  = '0;
        vcount    = 5'd16;
        capacity  = 10'd1023;

        // Directed table: two-vertex routes first, then a three-vertex case
        row_cfg(CFG_VERTEX_COUNT, 10'd2);
        row_item(CMD_EDGE, 0, 1, 10'd7, 0);
        row_item(CMD_DEMAND, 1, 0, 10'd3, 0);
        row_item(CMD_RUN, 0, 0, 10'd0, 3);
        typed(0, 0, 0, 0); typed(1, 0, 0, 0); typed(0, 14, 1, 0);
        // zero capacity: the lone customer never fits, abort at the depot
        row_cfg(CFG_CAPACITY, 10'd0);
        row_item(CMD_RUN, 0, 0, 10'd0, 2);
        typed(0, 0, 0, 0); typed(0, 0, 1, 1);
        // edge onto the diagonal sets the demand, zero demand fits
        row_item(CMD_EDGE, 1, 1, 10'd0, 0);
        row_item(CMD_RUN, 0, 0, 10'd0, 3);
        typed(0, 0, 0, 0); typed(1, 0, 0, 0); typed(0, 14, 1, 0);
        // blocked weight is never taken, one below it is
        row_item(CMD_EDGE, 1, 0, 10'd999, 0);
        row_item(CMD_RUN, 0, 0, 10'd0, 2);
        typed(0, 0, 0, 0); typed(0, 0, 1, 1);
        row_item(CMD_EDGE, 0, 1, 10'd998, 0);
        row_item(CMD_RUN, 0, 0, 10'd0, 3);
        typed(0, 0, 0, 0); typed(1, 0, 0, 0); typed(0, 1996, 1, 0);
        // vertex count below range clamps to two; demand equal to capacity fits
        row_cfg(CFG_VERTEX_COUNT, 10'd0);
        row_cfg(CFG_CAPACITY, 10'd1023);
        row_item(CMD_DEMAND, 1, 0, 10'd1023, 0);
        row_item(CMD_RUN, 0, 0, 10'd0, 3);
        typed(0, 0, 0, 0); typed(1, 0, 0, 0); typed(0, 1996, 1, 0);
        // unknown command is dropped; far corner of the store
        row_item(CMD_UNUSED, 15, 15, 10'd1023, 0);
        row_item(CMD_EDGE, 15, 14, 10'd1023, 0);
        // depot demand is ignored
        row_item(CMD_DEMAND, 0, 15, 10'd1023, 0);
        row_cfg(CFG_VERTEX_COUNT, 10'd1);
        row_item(CMD_RUN, 15, 15, 10'd1023, 3);
        typed(0, 0, 0, 0); typed(1, 0, 0, 0); typed(0, 1996, 1, 0);
        // tie on distance, capacity forces a depot return in between
        row_cfg(CFG_VERTEX_COUNT, 10'd3);
        row_cfg(CFG_CAPACITY, 10'd10);
        row_item(CMD_EDGE, 0, 2, 10'd5, 0);
        row_item(CMD_EDGE, 1, 2, 10'd4, 0);
        row_item(CMD_EDGE, 0, 1, 10'd5, 0);
        row_item(CMD_DEMAND, 1, 0, 10'd6, 0);
        row_item(CMD_DEMAND, 2, 0, 10'd6, 0);
        row_item(CMD_RUN, 0, 0, 10'd0, 0);

        // reset
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG)
                write_register(rows[i].idx, rows[i].amt);
            else
                send_item(rows[i].cmd, rows[i].a, rows[i].b, rows[i].amt, rows[i].typed_n);
        end

        // fill the whole store so any vertex count reads written entries only
        for (int a = 0; a < NV; a++) begin
            for (int b = a; b < NV; b++) begin
                send_item(CMD_EDGE, 4'(a), 4'(b),
                          (a == b) ? rand_demand() : rand_weight(), 0);
            end
        end

        // random phases
        while (items_sent < ITEM_GOAL) begin
            calm         = (items_sent >= ITEM_GOAL - CALM_ITEMS);
            idle_on      = ($urandom_range(0, 3) != 0);
            rx_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
            if ($urandom_range(0, 1) == 1)
                write_register(CFG_VERTEX_COUNT, ($urandom_range(0, 2) == 0) ?
                               10'd16 : 10'($urandom_range(0, 31)));
            if ($urandom_range(0, 1) == 1) begin
                roll = $urandom_range(0, 9);
                if (roll < 2) cap_pick = 10'd1023;
                else if (roll == 2) cap_pick = 10'd0;
                else if (roll < 7) cap_pick = 10'($urandom_range(20, 400));
                else cap_pick = 10'($urandom_range(0, 1023));
                write_register(CFG_CAPACITY, cap_pick);
            end
            batch = $urandom_range(3, 10);
            repeat (batch) begin
                roll = $urandom_range(0, 99);
                va   = 4'($urandom_range(0, 15));
                vb   = 4'($urandom_range(0, 15));
                if (roll < 35) send_item(CMD_RUN, va, vb, 10'($urandom), 0);
                else if (roll < 80) send_item(CMD_EDGE, va, vb, rand_weight(), 0);
                else if (roll < 95) send_item(CMD_DEMAND, va, vb, rand_demand(), 0);
                else send_item(CMD_UNUSED, va, vb, 10'($urandom), 0);
            end
        end

        // wind down
        drain();
        repeat (TAIL) @(negedge aclk);
        if (mismatches == 0 && expected_stops.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/gcrb_pkg.sv
hw/rtl/gcrb_dp.sv
hw/rtl/gcrb_ctrl.sv
hw/rtl/greedy_capacitated_route_builder.sv
tb/greedy_capacitated_route_builder_tb.sv
